// File: rtl/core/aes_ctr_pkg.sv
// Package for the AES-128 counter-mode keystream block: state type, S-box table,
// round constants and the key schedule step. Used by aes128_ctr_keystream_top and aes_ctr_round.
package aes_ctr_pkg;

  typedef enum logic [2:0] {
    ST_KEYX,
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } ctr_state_e;

  localparam int unsigned NumRoundKeys = 11;
  localparam int unsigned RkAddrW      = 4;
  localparam logic [RkAddrW-1:0] LastRound = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] rcon(input logic [RkAddrW-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of the 128-bit word sits at bits [8k+7:8k]; word n at [32n+31:32n].
  function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                  input logic [7:0]   rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
          SBOX[rk[111:104]] ^ rc};
    n0 = rk[31:0] ^ t;
    n1 = rk[63:32] ^ n0;
    n2 = rk[95:64] ^ n1;
    n3 = rk[127:96] ^ n2;
    return {n3, n2, n1, n0};
  endfunction

endpackage

// File: rtl/core/aes128_ctr_keystream_top.sv
// AES-128 counter-mode keystream top level. Uses aes_ctr_pkg, aes_ctr_ram, aes_ctr_round.
// Each keystream block passes through a load state that sets up the first round key read, eleven
// rounds through the shared round unit, and a done state that hands the block to the output register.
// A request runs for block_count blocks after its accept cycle, plus any output stalls.
// After reset and after each key write, the key schedule is rebuilt
// while no input item is accepted. Reset clears key, counter and control state.
module aes128_ctr_keystream_top
  import aes_ctr_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        load_counter_i,
  input  logic [63:0] counter_value_i,
  input  logic [6:0]  block_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] stream_low_o,
  output logic [63:0] stream_high_o,
  output logic [63:0] counter_used_o,
  output logic        last_o
);

  localparam logic [7:0] CfgKeyLow  = 8'd0;
  localparam logic [7:0] CfgKeyHigh = 8'd1;
  localparam logic [6:0] MaxCount   = 7'(MAX_BLOCKS);

  ctr_state_e state_q, state_d;
  logic [63:0]        key_lo_q, key_hi_q;
  logic               dirty_q, dirty_d;
  logic [RkAddrW-1:0] idx_q, idx_d;
  logic [127:0]       rk_q, rk_d;
  logic [127:0]       blk_q, blk_d;
  logic [63:0]        ctr_q, ctr_d;
  logic [6:0]         remain_q, remain_d;
  logic               out_vld_q, out_vld_d;
  logic [63:0]        out_lo_q, out_hi_q, out_ctr_q;
  logic               out_last_q;

  logic               cfg_wr, in_acc, out_load;
  logic               ram_we;
  logic [RkAddrW-1:0] ram_raddr;
  logic [127:0]       ram_wdata, ram_rdata, round_out;
  logic [6:0]         count_sat;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE) || dirty_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign count_sat   = (block_count_i > MaxCount) ? MaxCount : block_count_i;
  assign out_load    = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  aes_ctr_ram #(.Width(128), .Depth(NumRoundKeys)) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aes_ctr_round u_round (
    .state_i (blk_q),
    .rkey_i  (ram_rdata),
    .first_i (idx_q == '0),
    .last_i  (idx_q == LastRound),
    .state_o (round_out)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_KEYX: begin
        if (idx_q == LastRound) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (dirty_q && !cfg_wr) begin
          state_d = ST_KEYX;
        end else if (in_acc && count_sat != '0) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: begin
        if (idx_q == LastRound) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = (remain_q == 7'd1) ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    dirty_d   = dirty_q || cfg_wr;
    idx_d     = idx_q;
    rk_d      = rk_q;
    blk_d     = blk_q;
    ctr_d     = ctr_q;
    remain_d  = remain_q;
    out_vld_d = out_vld_q && out_stall_i;
    ram_we    = 1'b0;
    ram_wdata = (idx_q == '0) ? {key_hi_q, key_lo_q} : next_round_key(rk_q, rcon(idx_q));
    ram_raddr = '0;
    case (state_q)
      ST_KEYX: begin
        ram_we  = 1'b1;
        rk_d    = ram_wdata;
        idx_d   = idx_q + 1'b1;
        if (idx_q == LastRound) dirty_d = 1'b0;
      end
      ST_IDLE: begin
        idx_d = '0;
        if (in_acc) begin
          if (load_counter_i) ctr_d = counter_value_i;
          remain_d = count_sat;
        end
      end
      ST_LOAD: begin
        idx_d = '0;
        blk_d = {64'd0, ctr_q};
      end
      ST_ROUND: begin
        blk_d     = round_out;
        idx_d     = idx_q + 1'b1;
        ram_raddr = idx_q + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          ctr_d     = ctr_q + 64'd1;
          remain_d  = remain_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dirty_q   <= 1'b1;
      idx_q     <= '0;
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      ctr_q     <= '0;
      remain_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dirty_q   <= dirty_d;
      idx_q     <= idx_d;
      ctr_q     <= ctr_d;
      remain_q  <= remain_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr && cfg_index_i == CfgKeyLow)  key_lo_q <= cfg_data_i;
      if (cfg_wr && cfg_index_i == CfgKeyHigh) key_hi_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q  <= rk_d;
    blk_q <= blk_d;
    if (out_load) begin
      out_lo_q   <= blk_q[63:0];
      out_hi_q   <= blk_q[127:64];
      out_ctr_q  <= ctr_q;
      out_last_q <= (remain_q == 7'd1);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign stream_low_o   = out_lo_q;
  assign stream_high_o  = out_hi_q;
  assign counter_used_o = out_ctr_q;
  assign last_o         = out_last_q;

endmodule

// File: rtl/core/aes_ctr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module aes_ctr_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/aes_ctr_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns and AddRoundKey; AddRoundKey alone when first_i is set.
// Depends on aes_ctr_pkg for the S-box and xtime.
module aes_ctr_round
  import aes_ctr_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         first_i,
  input  logic         last_i,
  output logic [127:0] state_o
);

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [127:0] mixed;
  logic [127:0] shifted;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[8*i +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      shifted[32*c +: 32] = {t[4*c+3], t[4*c+2], t[4*c+1], t[4*c]};
      mixed[32*c +: 8]    = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1]
                            ^ t[4*c+2] ^ t[4*c+3];
      mixed[32*c+8 +: 8]  = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2])
                            ^ t[4*c+2] ^ t[4*c+3];
      mixed[32*c+16 +: 8] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2])
                            ^ xtime(t[4*c+3]) ^ t[4*c+3];
      mixed[32*c+24 +: 8] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                            ^ xtime(t[4*c+3]);
    end
    if (first_i) begin
      state_o = state_i ^ rkey_i;
    end else if (last_i) begin
      state_o = shifted ^ rkey_i;
    end else begin
      state_o = mixed ^ rkey_i;
    end
  end

endmodule
